FILE: rtl/core/tcp_receive_reassembly_queue_top_defines.svh
// Assertion macros used by the reassembly queue controller.
`ifndef TCP_RECEIVE_REASSEMBLY_QUEUE_TOP_DEFINES_SVH
`define TCP_RECEIVE_REASSEMBLY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TRRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/trrq_pkg.sv
`timescale 1ns / 1ps
package trrq_pkg;
  localparam int OPC_W  = 3;
  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 13;
  localparam int BYTE_W = 8;
  localparam int STS_W  = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;

  localparam logic [OPC_W-1:0] OP_RESTART   = 3'd0;
  localparam logic [OPC_W-1:0] OP_HEADER    = 3'd1;
  localparam logic [OPC_W-1:0] OP_DATA      = 3'd2;
  localparam logic [OPC_W-1:0] OP_READ_SEG  = 3'd3;
  localparam logic [OPC_W-1:0] OP_READ_BYTE = 3'd4;
  localparam logic [OPC_W-1:0] OP_QUERY     = 3'd5;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STS_W-1:0] ST_BEHIND   = 3'd2;
  localparam logic [STS_W-1:0] ST_NOFIT    = 3'd3;
  localparam logic [STS_W-1:0] ST_NOTREADY = 3'd4;
  localparam logic [STS_W-1:0] ST_NOP      = 3'd5;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_cap;
    logic scan_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic need_rd;
    logic need_scan;
    logic scan_done;
  } sts_t;
endpackage

FILE: rtl/core/trrq_ram.sv
`timescale 1ns / 1ps
module trrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/trrq_dp.sv
`timescale 1ns / 1ps
module trrq_dp #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trrq_pkg::cmd_t                    cmd,
  output trrq_pkg::sts_t                    sts,
  input  logic [trrq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [trrq_pkg::OPC_W-1:0]        in_tuser,
  output logic [trrq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [trrq_pkg::STS_W-1:0]        out_tuser,
  output logic                              out_tlast
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int SW = $clog2(MAX_SEGMENTS);
  localparam int LW = trrq_pkg::LEN_W;
  localparam int QW = trrq_pkg::SEQ_W;
  localparam int PW = ((AW > LW) ? AW : LW) + 2;
  localparam int TW = QW + LW;
  localparam logic [PW-1:0] BB_P     = PW'(BUFFER_BYTES);
  localparam logic [SW:0]   MS_C     = (SW + 1)'(MAX_SEGMENTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_SEGMENTS - 1);

  // Latched item.
  logic [trrq_pkg::OPC_W-1:0]  op_r, op_nxt;
  logic [QW-1:0]               seq_r, seq_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [trrq_pkg::BYTE_W-1:0] byte_r, byte_nxt;

  // Queue state.
  logic [QW-1:0]           cursor_r, cursor_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic                    ins_act_r, ins_act_nxt;
  logic [QW-1:0]           ins_seq_r, ins_seq_nxt;
  logic [LW-1:0]           ins_len_r, ins_len_nxt;
  logic [AW-1:0]           ins_pos_r, ins_pos_nxt;
  logic [LW-1:0]           ins_rem_r, ins_rem_nxt;
  logic [LW-1:0]           rd_rem_r, rd_rem_nxt;
  logic [MAX_SEGMENTS-1:0] valid_r, valid_nxt;

  // Scan results: front segment and lowest free slot.
  logic          best_found_r, best_found_nxt;
  logic [QW-1:0] best_dist_r, best_dist_nxt;
  logic [QW-1:0] best_seq_r, best_seq_nxt;
  logic [LW-1:0] best_len_r, best_len_nxt;
  logic [SW-1:0] best_idx_r, best_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;
  logic          proc_v_r, proc_v_nxt;
  logic [SW-1:0] proc_idx_r, proc_idx_nxt;

  // Result words.
  logic [trrq_pkg::STS_W-1:0]      res_status_r, res_status_nxt;
  logic [QW-1:0]                   res_seq_r, res_seq_nxt;
  logic [LW-1:0]                   res_len_r, res_len_nxt;
  logic [trrq_pkg::BYTE_W-1:0]     res_data_r, res_data_nxt;
  logic                            res_last_r, res_last_nxt;
  logic [trrq_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [trrq_pkg::STS_W-1:0]      out_tuser_r, out_tuser_nxt;
  logic                            out_tlast_r, out_tlast_nxt;

  logic                        byte_we;
  logic [trrq_pkg::BYTE_W-1:0] byte_rdata;
  logic                        tab_we;
  logic [TW-1:0]               tab_wd;
  logic [TW-1:0]               tab_rd;

  logic [QW-1:0] off, win_end, seg_dist, ready_end;
  logic          wrapz, behind, nofit, readable;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [PW-1:0] b);
    logic [PW-1:0] s;
    s = PW'(a) + b;
    if (s >= BB_P) begin
      s = s - BB_P;
    end
    return s[AW-1:0];
  endfunction

  trrq_ram #(.WIDTH(trrq_pkg::BYTE_W), .DEPTH(BUFFER_BYTES)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (ins_pos_r),
    .wdata (byte_r),
    .raddr (head_r),
    .rdata (byte_rdata)
  );

  trrq_ram #(.WIDTH(TW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (free_idx_r),
    .wdata (tab_wd),
    .raddr (cnt_r[SW-1:0]),
    .rdata (tab_rd)
  );

  assign off       = seq_r - cursor_r;
  assign win_end   = cursor_r + QW'(BUFFER_BYTES);
  assign wrapz     = (~cursor_r) < QW'(BUFFER_BYTES);
  // Near the top of sequence space the window wraps, so only the gap between
  // the window end and the cursor counts as behind.
  assign behind    = wrapz ? ((seq_r < cursor_r) && (seq_r >= win_end)) : (seq_r < cursor_r);
  assign nofit     = ({1'b0, off} + (QW + 1)'(len_r)) > (QW + 1)'(BUFFER_BYTES);
  assign readable  = best_found_r && (best_seq_r == cursor_r);
  assign ready_end = readable ? (cursor_r + QW'(best_len_r)) : cursor_r;
  assign seg_dist  = tab_rd[TW-1:LW] - cursor_r;

  always_comb begin
    op_nxt         = op_r;
    seq_nxt        = seq_r;
    len_nxt        = len_r;
    byte_nxt       = byte_r;
    cursor_nxt     = cursor_r;
    head_nxt       = head_r;
    ins_act_nxt    = ins_act_r;
    ins_seq_nxt    = ins_seq_r;
    ins_len_nxt    = ins_len_r;
    ins_pos_nxt    = ins_pos_r;
    ins_rem_nxt    = ins_rem_r;
    rd_rem_nxt     = rd_rem_r;
    valid_nxt      = valid_r;
    best_found_nxt = best_found_r;
    best_dist_nxt  = best_dist_r;
    best_seq_nxt   = best_seq_r;
    best_len_nxt   = best_len_r;
    best_idx_nxt   = best_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cnt_nxt        = cnt_r;
    proc_v_nxt     = proc_v_r;
    proc_idx_nxt   = proc_idx_r;
    res_status_nxt = res_status_r;
    res_seq_nxt    = res_seq_r;
    res_len_nxt    = res_len_r;
    res_data_nxt   = res_data_r;
    res_last_nxt   = res_last_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    byte_we        = 1'b0;
    tab_we         = 1'b0;
    tab_wd         = {ins_seq_r, ins_len_r};
    sts            = '0;

    if (cmd.latch) begin
      op_nxt   = in_tuser;
      seq_nxt  = in_tdata[31:0];
      len_nxt  = in_tdata[44:32];
      byte_nxt = in_tdata[52:45];
    end

    if (cmd.exec) begin
      res_status_nxt = trrq_pkg::ST_OK;
      res_seq_nxt    = '0;
      res_len_nxt    = '0;
      res_data_nxt   = '0;
      res_last_nxt   = 1'b0;
      case (op_r)
        trrq_pkg::OP_RESTART: begin
          cursor_nxt     = seq_r;
          head_nxt       = '0;
          valid_nxt      = '0;
          ins_act_nxt    = 1'b0;
          rd_rem_nxt     = '0;
          best_found_nxt = 1'b0;
          free_found_nxt = 1'b1;
          free_idx_nxt   = '0;
        end
        trrq_pkg::OP_HEADER: begin
          ins_act_nxt = 1'b0;
          if (!free_found_r) begin
            res_status_nxt = trrq_pkg::ST_FULL;
          end else if (behind) begin
            res_status_nxt = trrq_pkg::ST_BEHIND;
          end else if (nofit) begin
            res_status_nxt = trrq_pkg::ST_NOFIT;
          end else if (len_r == '0) begin
            tab_we                = 1'b1;
            tab_wd                = {seq_r, len_r};
            valid_nxt[free_idx_r] = 1'b1;
            sts.need_scan         = 1'b1;
          end else begin
            ins_act_nxt = 1'b1;
            ins_seq_nxt = seq_r;
            ins_len_nxt = len_r;
            ins_pos_nxt = ring_add(head_r, off[PW-1:0]);
            ins_rem_nxt = len_r;
          end
        end
        trrq_pkg::OP_DATA: begin
          if (!ins_act_r || ins_rem_r == '0) begin
            res_status_nxt = trrq_pkg::ST_NOP;
          end else begin
            byte_we     = 1'b1;
            ins_pos_nxt = ring_add(ins_pos_r, PW'(1));
            ins_rem_nxt = ins_rem_r - LW'(1);
            if (ins_rem_r == LW'(1)) begin
              tab_we                = 1'b1;
              valid_nxt[free_idx_r] = 1'b1;
              ins_act_nxt           = 1'b0;
              sts.need_scan         = 1'b1;
            end
          end
        end
        trrq_pkg::OP_READ_SEG: begin
          if (!readable) begin
            res_status_nxt = trrq_pkg::ST_NOTREADY;
          end else begin
            // Unread bytes of an earlier read are skipped here.
            head_nxt              = ring_add(head_r, PW'(rd_rem_r));
            res_seq_nxt           = best_seq_r;
            res_len_nxt           = best_len_r;
            valid_nxt[best_idx_r] = 1'b0;
            cursor_nxt            = cursor_r + QW'(best_len_r);
            rd_rem_nxt            = best_len_r;
            sts.need_scan         = 1'b1;
          end
        end
        trrq_pkg::OP_READ_BYTE: begin
          if (rd_rem_r == '0) begin
            res_status_nxt = trrq_pkg::ST_NOP;
          end else begin
            sts.need_rd  = 1'b1;
            head_nxt     = ring_add(head_r, PW'(1));
            rd_rem_nxt   = rd_rem_r - LW'(1);
            res_last_nxt = (rd_rem_r == LW'(1));
          end
        end
        trrq_pkg::OP_QUERY: begin
        end
        default: begin
          res_status_nxt = trrq_pkg::ST_NOP;
        end
      endcase
      if (sts.need_scan) begin
        cnt_nxt        = '0;
        proc_v_nxt     = 1'b0;
        best_found_nxt = 1'b0;
        free_found_nxt = 1'b0;
      end
    end

    if (cmd.rd_cap) begin
      res_data_nxt = byte_rdata;
    end

    // The table read is registered, so each entry is judged in the cycle after
    // its address goes out.
    if (cmd.scan_step) begin
      proc_v_nxt   = cnt_r < MS_C;
      proc_idx_nxt = cnt_r[SW-1:0];
      if (cnt_r < MS_C) begin
        cnt_nxt = cnt_r + (SW + 1)'(1);
      end
      if (proc_v_r) begin
        if (valid_r[proc_idx_r]) begin
          if (!best_found_r || seg_dist < best_dist_r) begin
            best_found_nxt = 1'b1;
            best_dist_nxt  = seg_dist;
            best_seq_nxt   = tab_rd[TW-1:LW];
            best_len_nxt   = tab_rd[LW-1:0];
            best_idx_nxt   = proc_idx_r;
          end
        end else if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = proc_idx_r;
        end
      end
      sts.scan_done = proc_v_r && (proc_idx_r == LAST_IDX);
    end

    if (cmd.publish) begin
      out_tuser_nxt = res_status_r;
      out_tlast_nxt = res_last_r;
      out_tdata_nxt = {2'b00, ready_end, readable, res_data_r, res_len_r, res_seq_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      head_r       <= '0;
      ins_act_r    <= 1'b0;
      ins_rem_r    <= '0;
      rd_rem_r     <= '0;
      valid_r      <= '0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b1;
      free_idx_r   <= '0;
      cnt_r        <= '0;
      proc_v_r     <= 1'b0;
    end else begin
      cursor_r     <= cursor_nxt;
      head_r       <= head_nxt;
      ins_act_r    <= ins_act_nxt;
      ins_rem_r    <= ins_rem_nxt;
      rd_rem_r     <= rd_rem_nxt;
      valid_r      <= valid_nxt;
      best_found_r <= best_found_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      cnt_r        <= cnt_nxt;
      proc_v_r     <= proc_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    seq_r        <= seq_nxt;
    len_r        <= len_nxt;
    byte_r       <= byte_nxt;
    ins_seq_r    <= ins_seq_nxt;
    ins_len_r    <= ins_len_nxt;
    ins_pos_r    <= ins_pos_nxt;
    best_dist_r  <= best_dist_nxt;
    best_seq_r   <= best_seq_nxt;
    best_len_r   <= best_len_nxt;
    best_idx_r   <= best_idx_nxt;
    proc_idx_r   <= proc_idx_nxt;
    res_status_r <= res_status_nxt;
    res_seq_r    <= res_seq_nxt;
    res_len_r    <= res_len_nxt;
    res_data_r   <= res_data_nxt;
    res_last_r   <= res_last_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
    out_tlast_r  <= out_tlast_nxt;
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_tlast = out_tlast_r;
endmodule

FILE: rtl/core/trrq_ctrl.sv
`timescale 1ns / 1ps
`include "tcp_receive_reassembly_queue_top_defines.svh"
module trrq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output trrq_pkg::cmd_t cmd,
  input  trrq_pkg::sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RDWAIT, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.latch     = (state_r == S_IDLE) && in_tvalid;
    cmd.exec      = (state_r == S_EXEC);
    cmd.rd_cap    = (state_r == S_RDWAIT);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.publish   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
    state_nxt     = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_rd) begin
          state_nxt = S_RDWAIT;
        end else if (sts.need_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDWAIT: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.publish) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  `TRRQ_ASSERT_IMP(a_no_overwrite, cmd.publish, !out_tvalid_r || out_tready, "result overwritten while held")
  `TRRQ_ASSERT_NXT(a_exec_follows, in_tvalid && in_tready, state_r == S_EXEC, "accepted word not executed")
  `TRRQ_ASSERT_NXT(a_scan_ends, state_r == S_SCAN && sts.scan_done, state_r == S_DONE, "scan did not finish")
endmodule

FILE: rtl/core/tcp_receive_reassembly_queue_top.sv
`timescale 1ns / 1ps
// TCP receive reassembly queue. Each input word carries an opcode in in_tuser
// and produces exactly one result word. Restart, header, data byte, query and
// rejected operations pass through accept, execute and publish; read byte
// adds a wait for the registered byte-ring read. An operation that changes
// the segment table (a committed segment or a read segment) then adds a scan,
// during which the table memory is swept through its single read port to
// find the front segment and the lowest free slot. A new word is taken once
// the previous result has been loaded into the output register, where it may
// still wait to be taken; while that register is still full, a finished
// result waits and the input is held off.
module tcp_receive_reassembly_queue_top #(
  parameter int BUFFER_BYTES = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seq [31:0], length [44:32], data_byte [52:45], zero fill [55:53]
  input  logic [trrq_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode
  input  logic [trrq_pkg::OPC_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // seq_out [31:0], length_out [44:32], data_out [52:45], readable [53],
  // end of the readable span [85:54], zero fill [87:86]
  output logic [trrq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic [trrq_pkg::STS_W-1:0]       out_tuser,
  output logic                             out_tlast
);
  trrq_pkg::cmd_t cmd;
  trrq_pkg::sts_t sts;

  trrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  trrq_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );
endmodule

FILE: tb/sv/tcp_receive_reassembly_queue_top_tb.sv
`timescale 1ns / 1ps
module tcp_receive_reassembly_queue_top_tb;
  localparam int BUF_BYTES = 4096;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int NSEG      = 16;
  localparam int RAND_WORDS = 1100;

  typedef struct {
    logic [trrq_pkg::STS_W-1:0]  status;
    logic [trrq_pkg::SEQ_W-1:0]  seq_out;
    logic [trrq_pkg::LEN_W-1:0]  len_out;
    logic [trrq_pkg::BYTE_W-1:0] data_out;
    logic                        last;
    logic                        readable;
    logic [trrq_pkg::SEQ_W-1:0]  ready_limit;
  } seg_result_t;

  typedef struct {
    logic [trrq_pkg::OPC_W-1:0]  op;
    logic [trrq_pkg::SEQ_W-1:0]  seq;
    logic [trrq_pkg::LEN_W-1:0]  len;
    logic [trrq_pkg::BYTE_W-1:0] data;
    bit                          known;
    logic [trrq_pkg::STS_W-1:0]  status;
  } stim_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [trrq_pkg::IN_DATA_W-1:0] in_tdata;
  logic [trrq_pkg::OPC_W-1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [trrq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [trrq_pkg::STS_W-1:0] out_tuser;
  logic out_tlast;

  tcp_receive_reassembly_queue_top #(.BUFFER_BYTES(BUF_BYTES), .MAX_SEGMENTS(NSEG)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow of the reassembly state.
  logic [31:0] cursor;
  int unsigned ring_head;
  logic [7:0]  ring_bytes [BUF_BYTES];
  bit          ring_written [BUF_BYTES];
  logic [31:0] tab_seq [NSEG];
  logic [12:0] tab_len [NSEG];
  bit          tab_valid [NSEG];
  bit          ins_active;
  logic [31:0] ins_seq;
  logic [12:0] ins_len;
  int unsigned ins_pos, ins_left;
  int unsigned read_left;

  seg_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tcp_receive_reassembly_queue_top regression: fail");
    $finish;
  end

  function automatic int front_slot();
    int best;
    logic [31:0] best_dist, d;
    best = -1;
    best_dist = '0;
    for (int i = 0; i < NSEG; i++) begin
      if (tab_valid[i]) begin
        d = tab_seq[i] - cursor;
        if (best < 0 || d < best_dist) begin
          best = i;
          best_dist = d;
        end
      end
    end
    return best;
  endfunction

  function automatic int readable_slot();
    int f;
    f = front_slot();
    if (f >= 0 && tab_seq[f] == cursor) return f;
    return -1;
  endfunction

  function automatic void commit_segment();
    for (int i = 0; i < NSEG; i++) begin
      if (!tab_valid[i]) begin
        tab_valid[i] = 1'b1;
        tab_seq[i] = ins_seq;
        tab_len[i] = ins_len;
        break;
      end
    end
    ins_active = 1'b0;
  endfunction

  function automatic logic [trrq_pkg::STS_W-1:0] accept_header(logic [31:0] seq,
                                                               logic [12:0] len);
    int n;
    logic [31:0] off, wrap_edge;
    ins_active = 1'b0;
    n = 0;
    foreach (tab_valid[i]) if (tab_valid[i]) n++;
    if (n >= NSEG) return trrq_pkg::ST_FULL;
    // Near the top of the sequence space the window wraps round to zero.
    if (32'hFFFF_FFFF - cursor < BUF_BYTES) begin
      wrap_edge = cursor + BUF_BYTES;
      if (seq < cursor && seq >= wrap_edge) return trrq_pkg::ST_BEHIND;
    end else if (seq < cursor) begin
      return trrq_pkg::ST_BEHIND;
    end
    off = seq - cursor;
    if (64'(off) + 64'(len) > BUF_BYTES) return trrq_pkg::ST_NOFIT;
    ins_active = 1'b1;
    ins_seq = seq;
    ins_len = len;
    ins_pos = (ring_head + off) % BUF_BYTES;
    ins_left = 32'(len);
    if (len == 0) commit_segment();
    return trrq_pkg::ST_OK;
  endfunction

  function automatic seg_result_t reassemble(logic [2:0] op, logic [31:0] seq,
                                             logic [12:0] len, logic [7:0] data);
    seg_result_t r;
    int f;
    r = '{default: '0};
    case (op)
      trrq_pkg::OP_RESTART: begin
        cursor = seq;
        ring_head = 0;
        foreach (tab_valid[i]) tab_valid[i] = 1'b0;
        ins_active = 1'b0;
        read_left = 0;
      end
      trrq_pkg::OP_HEADER: r.status = accept_header(seq, len);
      trrq_pkg::OP_DATA: begin
        if (!ins_active || ins_left == 0) begin
          r.status = trrq_pkg::ST_NOP;
        end else begin
          ring_bytes[BUF_AW'(ins_pos)] = data;
          ring_written[BUF_AW'(ins_pos)] = 1'b1;
          ins_pos = (ins_pos + 1) % BUF_BYTES;
          ins_left--;
          if (ins_left == 0) commit_segment();
        end
      end
      trrq_pkg::OP_READ_SEG: begin
        f = readable_slot();
        if (f < 0) begin
          r.status = trrq_pkg::ST_NOTREADY;
        end else begin
          ring_head = (ring_head + read_left) % BUF_BYTES;
          r.seq_out = tab_seq[f];
          r.len_out = tab_len[f];
          tab_valid[f] = 1'b0;
          cursor = cursor + tab_len[f];
          read_left = 32'(tab_len[f]);
        end
      end
      trrq_pkg::OP_READ_BYTE: begin
        if (read_left == 0) begin
          r.status = trrq_pkg::ST_NOP;
        end else begin
          r.data_out = ring_bytes[BUF_AW'(ring_head)];
          ring_head = (ring_head + 1) % BUF_BYTES;
          read_left--;
          r.last = (read_left == 0);
        end
      end
      trrq_pkg::OP_QUERY: ;
      default: r.status = trrq_pkg::ST_NOP;
    endcase
    f = readable_slot();
    r.readable = (f >= 0);
    r.ready_limit = (f >= 0) ? cursor + tab_len[f] : cursor;
    return r;
  endfunction

  // Offers one word, waits for it to be taken, then records what it should produce.
  task automatic send_word(logic [2:0] op, logic [31:0] seq, logic [12:0] len,
                           logic [7:0] data, bit known = 1'b0,
                           logic [trrq_pkg::STS_W-1:0] known_status = trrq_pkg::ST_OK);
    seg_result_t r;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, data, len, seq};
    do @(posedge clk); while (!in_tready);
    r = reassemble(op, seq, len, data);
    if (known) r.status = known_status;
    pending_results.push_back(r);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    seg_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: tuser 0x%0h tdata 0x%0h",
               out_tuser, out_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_tuser));
        check_field("seq_out", e.seq_out, out_tdata[31:0]);
        check_field("length_out", 32'(e.len_out), 32'(out_tdata[44:32]));
        check_field("data_out", 32'(e.data_out), 32'(out_tdata[52:45]));
        check_field("last", 32'(e.last), 32'(out_tlast));
        check_field("readable", 32'(e.readable), 32'(out_tdata[53]));
        check_field("ready_limit", e.ready_limit, out_tdata[85:54]);
      end
    end
  end

  // Result side: stalls in patterns of varying density, plus one long hold-off.
  initial begin
    int cycles, mode, run;
    bit held;
    cycles = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      run = $urandom_range(5, 60);
      repeat (run) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
        cycles++;
      end
      if (!held && cycles > 1500) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  stim_row_t directed [24] = '{
    '{trrq_pkg::OP_QUERY,     32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_DATA,      32'h0,         13'd0,    8'h5A, 1'b1, trrq_pkg::ST_NOP},
    '{trrq_pkg::OP_READ_BYTE, 32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_NOP},
    '{trrq_pkg::OP_READ_SEG,  32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_NOTREADY},
    '{3'd6,                   32'hFFFF_FFFF, 13'h1FFF, 8'hFF, 1'b1, trrq_pkg::ST_NOP},
    '{3'd7,                   32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_NOP},
    '{trrq_pkg::OP_HEADER,    32'h0,         13'h1FFF, 8'h00, 1'b1, trrq_pkg::ST_NOFIT},
    '{trrq_pkg::OP_HEADER,    32'h0,         13'd2,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_DATA,      32'h0,         13'd0,    8'hFF, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_DATA,      32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_HEADER,    32'd10,        13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_SEG,  32'h0,         13'd0,    8'h00, 1'b0, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_BYTE, 32'h0,         13'd0,    8'h00, 1'b0, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_BYTE, 32'h0,         13'd0,    8'h00, 1'b0, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_HEADER,    32'hFFFF_FFFF, 13'd1,    8'h00, 1'b1, trrq_pkg::ST_NOFIT},
    '{trrq_pkg::OP_RESTART,   32'hFFFF_F800, 13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_HEADER,    32'h0000_0100, 13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_HEADER,    32'hFFFF_F000, 13'd1,    8'h00, 1'b1, trrq_pkg::ST_BEHIND},
    '{trrq_pkg::OP_HEADER,    32'hFFFF_F800, 13'd4096, 8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_SEG,  32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_NOTREADY},
    '{trrq_pkg::OP_HEADER,    32'hFFFF_F800, 13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_SEG,  32'h0,         13'd0,    8'h00, 1'b0, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_READ_SEG,  32'h0,         13'd0,    8'h00, 1'b0, trrq_pkg::ST_OK},
    '{trrq_pkg::OP_RESTART,   32'h0,         13'd0,    8'h00, 1'b1, trrq_pkg::ST_OK}
  };

  initial begin
    int kind, nbytes, next_pause;
    logic [31:0] off;
    logic [12:0] len;
    logic [2:0] op;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    cursor = '0;
    ring_head = 0;
    ins_active = 1'b0;
    ins_pos = 0;
    ins_left = 0;
    read_left = 0;
    foreach (tab_valid[i]) tab_valid[i] = 1'b0;
    foreach (ring_written[i]) ring_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].op, directed[i].seq, directed[i].len, directed[i].data,
                directed[i].known, directed[i].status);

    next_pause = words_sent + 300;
    while (words_sent < RAND_WORDS + $size(directed)) begin
      if (words_sent >= next_pause) begin
        wait_drained();
        next_pause = words_sent + 300;
      end
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        if ($urandom_range(0, 2) == 0)
          send_word(trrq_pkg::OP_RESTART, 32'hFFFF_FFFF - $urandom_range(0, 6000), '0, '0);
        else
          send_word(trrq_pkg::OP_RESTART, $urandom, '0, '0);
      end else if (kind < 52) begin
        // A segment: mostly near the cursor and in order, sometimes far off.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: off = 0;
          4, 5, 6, 7: off = $urandom_range(0, 64);
          8: off = BUF_BYTES - $urandom_range(0, 16);
          default: off = $urandom;
        endcase
        if ($urandom_range(0, 39) == 0) len = 13'($urandom_range(0, 400));
        else len = 13'($urandom_range(0, 12));
        nbytes = int'(len);
        if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, len);
        send_word(trrq_pkg::OP_HEADER, cursor + off, len, 8'($urandom));
        repeat (nbytes) send_word(trrq_pkg::OP_DATA, $urandom, 13'($urandom), 8'($urandom));
      end else if (kind < 82) begin
        send_word(trrq_pkg::OP_READ_SEG, $urandom, 13'($urandom), 8'($urandom));
        nbytes = read_left;
        if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, read_left);
        repeat (nbytes) begin
          // Never fetch a ring byte that no segment has written yet.
          if (ring_written[BUF_AW'(ring_head)])
            send_word(trrq_pkg::OP_READ_BYTE, $urandom, 13'($urandom), 8'($urandom));
          else
            send_word(trrq_pkg::OP_QUERY, $urandom, 13'($urandom), 8'($urandom));
        end
      end else if (kind < 90) begin
        send_word(trrq_pkg::OP_QUERY, $urandom, 13'($urandom), 8'($urandom));
      end else begin
        op = 3'($urandom_range(1, 7));
        if (op == trrq_pkg::OP_READ_BYTE && read_left != 0 &&
            !ring_written[BUF_AW'(ring_head)])
          op = trrq_pkg::OP_QUERY;
        send_word(op, $urandom, 13'($urandom), 8'($urandom));
      end
    end

    wait_drained();
    repeat (NSEG + 20) @(posedge clk);
    if (errors == 0) begin
      $display("tcp_receive_reassembly_queue_top regression: pass");
    end else begin
      $display("tcp_receive_reassembly_queue_top regression: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/trrq_pkg.sv
rtl/core/trrq_ram.sv
rtl/core/trrq_dp.sv
rtl/core/trrq_ctrl.sv
rtl/core/tcp_receive_reassembly_queue_top.sv
tb/sv/tcp_receive_reassembly_queue_top_tb.sv
